[rtl/core/cdp_pkg.sv]
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types and constants for the capability descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cdp_pkg;

    localparam int CDP_MASK_BITS  = 128;   // default access mask size
    localparam int MASK_READ_BITS = 128;   // two 64-bit words reachable by a read
    localparam int GROUP_BITS     = 24;    // bits carried by one mask group
    localparam logic [31:0] PAGE_BYTES = 32'd4096;
    localparam logic [31:0] DESC_UNUSED = 32'hFFFF_FFFF;

    // Result kind codes as seen on the output channel
    typedef enum logic [3:0] {
        KIND_UNUSED        = 4'd0,
        KIND_IRQ           = 4'd1,
        KIND_MASK          = 4'd2,
        KIND_HANDLES       = 4'd3,
        KIND_FLAGS         = 4'd4,
        KIND_RANGE_PENDING = 4'd5,
        KIND_RANGE_MAPPED  = 4'd6,
        KIND_PAGE          = 4'd7,
        KIND_VERSION       = 4'd8,
        KIND_UNHANDLED     = 4'd9,
        KIND_READ          = 4'd10
    } t_kind;

    // Operation decoded by the front end
    typedef enum logic [3:0] {
        OP_UNUSED,
        OP_IRQ,
        OP_MASK,
        OP_HANDLES,
        OP_FLAGS,
        OP_RANGE,
        OP_PAGE,
        OP_VERSION,
        OP_UNHANDLED,
        OP_READ
    } t_op;

    // Classified command passed through the queue
    typedef struct packed {
        t_op         op;
        logic [31:0] desc;
        logic        last;
        logic        widx;
        logic [23:0] mask_act;   // bit k set: group bit k is written
        logic [7:0]  mask_base;  // first mask bit of the group
    } t_cmd;

    // Queue status seen by the back end and the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage : cdp_pkg

`default_nettype wire

[rtl/core/cdp_if.sv]
// ----------------------------------------------------------------------------
// cdp_if
// Valid/ready channels of the capability descriptor parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdp_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] descriptor;
    logic        last;
    logic        mask_word_index;

    modport source (output valid, func, descriptor, last, mask_word_index, input ready);
    modport sink   (input valid, func, descriptor, last, mask_word_index, output ready);
endinterface : cdp_in_if

interface cdp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] map_address;
    logic [31:0] map_size;
    logic        map_read_only;
    logic        map_unk_flag;
    logic [9:0]  handle_count;
    logic [15:0] misc_flag_bits;
    logic [15:0] version_word;
    logic [63:0] mask_word;

    modport source (
        output valid, kind, map_address, map_size, map_read_only, map_unk_flag,
               handle_count, misc_flag_bits, version_word, mask_word,
        input  ready
    );
    modport sink (
        input  valid, kind, map_address, map_size, map_read_only, map_unk_flag,
               handle_count, misc_flag_bits, version_word, mask_word,
        output ready
    );
endinterface : cdp_out_if

`default_nettype wire

[rtl/core/capability_descriptor_parser_top.sv]
// ----------------------------------------------------------------------------
// capability_descriptor_parser_top
// Capability descriptor parser: classifies 32-bit descriptors, keeps the
// syscall access mask and kernel parameters, and emits memory mappings.
// ----------------------------------------------------------------------------
// Every accepted item (a descriptor to parse or a mask word read) yields
// exactly one result transfer, in order. The block takes one item per clock
// while the queue has room: the front end classifies the descriptor in the
// accept cycle and writes it into a two-entry queue; the back end executes
// one queued command per cycle into the output register while that register
// is empty or being taken, so a result appears in the cycle after the
// command leaves the queue. A downstream stall fills the queue; the input
// stalls only when both entries are taken. A range start descriptor is held
// by the back end and paired with the very next parsed descriptor if that
// one is a range word; mask reads in between leave it pending. The access
// mask is MASK_BITS wide and cleared by reset; reads reach the first two
// 64-bit words, bits beyond MASK_BITS read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module capability_descriptor_parser_top #(
    parameter int MASK_BITS = cdp_pkg::CDP_MASK_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdp_in_if.sink     i_in,
    cdp_out_if.source  o_out
);
    import cdp_pkg::*;

    t_cmd    w_front_cmd;   // classified command from the front end
    t_cmd    w_back_cmd;    // head of the queue
    t_q_stat w_q_stat;      // queue full/empty
    logic    w_push;        // input transfer
    logic    w_pop;         // back end takes the queue head

    // Input transfer whenever the queue has room
    assign i_in.ready = !w_q_stat.full;
    assign w_push     = i_in.valid && i_in.ready;

    cdp_front u_front (
        .i_func       (i_in.func),
        .i_descriptor (i_in.descriptor),
        .i_last       (i_in.last),
        .i_widx       (i_in.mask_word_index),
        .o_cmd        (w_front_cmd)
    );

    cdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_stat  (w_q_stat)
    );

    cdp_back #(
        .MASK_BITS (MASK_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_back_cmd),
        .i_stat  (w_q_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // Queue cannot report full and empty at once
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue full and empty together");

    // A command taken by the back end shows up as a result next cycle
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out.valid)
        else $error("popped command produced no result");

    // A transfer in without a pop leaves the queue non-empty
    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> !w_q_stat.empty)
        else $error("pushed command lost");

    // Back end never pops an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

endmodule : capability_descriptor_parser_top

`default_nettype wire

[rtl/core/cdp_front.sv]
// ----------------------------------------------------------------------------
// cdp_front
// Classifies an incoming item by descriptor prefix and precomputes the
// mask group write window.
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_front (
    input  wire logic         i_func,
    input  wire logic [31:0]  i_descriptor,
    input  wire logic         i_last,
    input  wire logic         i_widx,
    output cdp_pkg::t_cmd     o_cmd
);
    import cdp_pkg::*;

    logic [11:0] w_type;
    t_op         w_op;
    logic [23:0] w_act;

    assign w_type = i_descriptor[31:20];

    always_comb begin
        if (i_func) begin
            w_op = OP_READ;
        end else if (i_descriptor == DESC_UNUSED) begin
            w_op = OP_UNUSED;
        end else if ((w_type & 12'hF00) == 12'hE00) begin
            w_op = OP_IRQ;
        end else if ((w_type & 12'hF80) == 12'hF00) begin
            w_op = OP_MASK;
        end else if ((w_type & 12'hFF0) == 12'hFE0) begin
            w_op = OP_HANDLES;
        end else if ((w_type & 12'hFF8) == 12'hFF0) begin
            w_op = OP_FLAGS;
        end else if ((w_type & 12'hFFE) == 12'hFF8) begin
            w_op = OP_RANGE;
        end else if (w_type == 12'hFFE) begin
            w_op = OP_PAGE;
        end else if ((w_type & 12'hFE0) == 12'hFC0) begin
            w_op = OP_VERSION;
        end else begin
            w_op = OP_UNHANDLED;
        end
    end

    // Write stops after the highest set bit: bit k is active if any bit >= k is set
    always_comb begin
        for (int k = 0; k < GROUP_BITS; k++) begin
            w_act[k] = |(i_descriptor[23:0] >> k);
        end
    end

    always_comb begin
        o_cmd.op        = w_op;
        o_cmd.desc      = i_descriptor;
        o_cmd.last      = i_last;
        o_cmd.widx      = i_widx;
        o_cmd.mask_act  = w_act;
        // group * 24 = group * 16 + group * 8
        o_cmd.mask_base = {1'b0, i_descriptor[26:24], 4'b0000}
                        + {2'b00, i_descriptor[26:24], 3'b000};
    end

endmodule : cdp_front

`default_nettype wire

[rtl/core/cdp_queue.sv]
// ----------------------------------------------------------------------------
// cdp_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cdp_pkg::t_cmd   i_cmd,
    input  wire logic            i_pop,
    output cdp_pkg::t_cmd        o_cmd,
    output wire cdp_pkg::t_q_stat o_stat
);
    import cdp_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = r_cnt[1];
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule : cdp_queue

`default_nettype wire

[rtl/core/cdp_back.sv]
// ----------------------------------------------------------------------------
// cdp_back
// Executes classified commands against the parser state and holds the
// result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdp_back #(
    parameter int MASK_BITS = cdp_pkg::CDP_MASK_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cdp_pkg::t_cmd    i_cmd,
    input  wire cdp_pkg::t_q_stat i_stat,
    output logic                  o_pop,
    cdp_out_if.source             o_out
);
    import cdp_pkg::*;

    // State
    logic [MASK_BITS-1:0] r_mask;
    logic                 r_pend;
    logic [20:0]          r_pstart;
    logic [9:0]           r_handles;
    logic [15:0]          r_flags;
    logic [15:0]          r_version;

    logic [MASK_BITS-1:0] n_mask;
    logic                 n_pend;
    logic [20:0]          n_pstart;
    logic [9:0]           n_handles;
    logic [15:0]          n_flags;
    logic [15:0]          n_version;

    // Result register
    logic        r_valid;
    t_kind       r_kind;
    logic [31:0] r_addr;
    logic [31:0] r_size;
    logic        r_ro;
    logic        r_unk;
    logic [63:0] r_mword;

    t_kind       n_kind;
    logic [31:0] n_addr;
    logic [31:0] n_size;
    logic        n_ro;
    logic        n_unk;
    logic [63:0] n_mword;

    logic [MASK_READ_BITS-1:0] w_pad;
    logic [31:0]               w_start;
    logic [31:0]               w_end;

    for (genvar i = 0; i < MASK_READ_BITS; i++) begin : g_pad
        if (i < MASK_BITS) begin : g_bit
            assign w_pad[i] = r_mask[i];
        end else begin : g_zero
            assign w_pad[i] = 1'b0;
        end
    end

    assign o_pop   = !i_stat.empty && (!r_valid || o_out.ready);
    assign w_start = {r_pstart[19:0], 12'h000};
    assign w_end   = {i_cmd.desc[19:0], 12'h000};

    always_comb begin
        int off;
        off       = 0;
        n_mask    = r_mask;
        n_pend    = r_pend;
        n_pstart  = r_pstart;
        n_handles = r_handles;
        n_flags   = r_flags;
        n_version = r_version;
        n_kind    = KIND_UNHANDLED;
        n_addr    = '0;
        n_size    = '0;
        n_ro      = 1'b0;
        n_unk     = 1'b0;
        n_mword   = '0;

        if (i_cmd.op == OP_READ) begin
            n_kind  = KIND_READ;
            n_mword = i_cmd.widx ? w_pad[127:64] : w_pad[63:0];
        end else if (r_pend && i_cmd.op == OP_RANGE) begin
            n_kind = KIND_RANGE_MAPPED;
            n_addr = w_start;
            n_size = (w_end > w_start) ? (w_end - w_start) : 32'd0;
            n_ro   = r_pstart[20];
            n_unk  = i_cmd.desc[20];
            n_pend = 1'b0;
        end else begin
            n_pend = 1'b0;
            case (i_cmd.op)
                OP_UNUSED: begin
                    n_kind = KIND_UNUSED;
                end
                OP_IRQ: begin
                    n_kind = KIND_IRQ;
                end
                OP_MASK: begin
                    n_kind = KIND_MASK;
                    for (int n = 0; n < MASK_BITS; n++) begin
                        off = n - int'(i_cmd.mask_base);
                        if (off >= 0 && off < GROUP_BITS) begin
                            if (i_cmd.mask_act[off[4:0]]) begin
                                n_mask[n] = i_cmd.desc[off[4:0]];
                            end
                        end
                    end
                end
                OP_HANDLES: begin
                    n_kind    = KIND_HANDLES;
                    n_handles = i_cmd.desc[9:0];
                end
                OP_FLAGS: begin
                    n_kind  = KIND_FLAGS;
                    n_flags = i_cmd.desc[15:0];
                end
                OP_RANGE: begin
                    n_kind = KIND_RANGE_PENDING;
                    if (!i_cmd.last) begin
                        n_pend   = 1'b1;
                        n_pstart = i_cmd.desc[20:0];
                    end
                end
                OP_PAGE: begin
                    n_kind = KIND_PAGE;
                    n_addr = w_end;
                    n_size = PAGE_BYTES;
                end
                OP_VERSION: begin
                    n_kind    = KIND_VERSION;
                    n_version = i_cmd.desc[15:0];
                end
                default: begin
                    n_kind = KIND_UNHANDLED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_pend    <= 1'b0;
            r_pstart  <= '0;
            r_handles <= '0;
            r_flags   <= '0;
            r_version <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask    <= n_mask;
                r_pend    <= n_pend;
                r_pstart  <= n_pstart;
                r_handles <= n_handles;
                r_flags   <= n_flags;
                r_version <= n_version;
                r_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= n_kind;
            r_addr  <= n_addr;
            r_size  <= n_size;
            r_ro    <= n_ro;
            r_unk   <= n_unk;
            r_mword <= n_mword;
        end
    end

    // Register fields report the state after the step, held with the result
    logic [9:0]  r_out_handles;
    logic [15:0] r_out_flags;
    logic [15:0] r_out_version;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_handles <= n_handles;
            r_out_flags   <= n_flags;
            r_out_version <= n_version;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_kind;
    assign o_out.map_address    = r_addr;
    assign o_out.map_size       = r_size;
    assign o_out.map_read_only  = r_ro;
    assign o_out.map_unk_flag   = r_unk;
    assign o_out.handle_count   = r_out_handles;
    assign o_out.misc_flag_bits = r_out_flags;
    assign o_out.version_word   = r_out_version;
    assign o_out.mask_word      = r_mword;

endmodule : cdp_back

`default_nettype wire

[verif/tb_capability_descriptor_parser_top.sv]
// ----------------------------------------------------------------------------
// tb_capability_descriptor_parser_top
// Self-checking bench for the capability descriptor parser. A scoreboard
// predicts one result per accepted item from its own copy of the access mask,
// the pending range start and the kernel parameter registers; every output
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_capability_descriptor_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdp_pkg::*;

    localparam int MASK_BITS   = CDP_MASK_BITS;
    localparam int MASK_WORDS  = (MASK_BITS + 63) / 64;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 80;

    // func field of an input transfer
    localparam bit FUNC_PARSE = 1'b0;
    localparam bit FUNC_READ  = 1'b1;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] map_address;
        logic [31:0] map_size;
        logic        map_read_only;
        logic        map_unk_flag;
        logic [9:0]  handle_count;
        logic [15:0] misc_flag_bits;
        logic [15:0] version_word;
        logic [63:0] mask_word;
    } t_parse_result;

    // ------------------------------------------------------------------------
    // Scoreboard: descriptor predictor plus in-order result check
    // ------------------------------------------------------------------------
    class t_descriptor_scoreboard;
        logic [63:0]   access_words [MASK_WORDS];
        bit            range_held;
        logic [20:0]   held_start;
        logic [9:0]    handle_size;
        logic [15:0]   misc_flags;
        logic [15:0]   version_hold;
        t_parse_result expected_results [$];
        int            errors;

        function new();
            foreach (access_words[i]) access_words[i] = '0;
            range_held   = 1'b0;
            held_start   = '0;
            handle_size  = '0;
            misc_flags   = '0;
            version_hold = '0;
            errors       = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Predict the result of one accepted input transfer.
        function void accept_item(bit func, logic [31:0] desc, bit last, bit widx);
            t_parse_result r;
            logic [11:0]   prefix;
            logic [31:0]   range_end;
            int unsigned   group_base;
            int unsigned   pos;
            r      = '0;
            r.kind = KIND_UNHANDLED;
            prefix = desc[31:20];
            if (func == FUNC_READ) begin
                r.kind = KIND_READ;
                if (widx < MASK_WORDS) r.mask_word = access_words[widx];
            end else if (range_held && (prefix & 12'hFFE) == 12'hFF8) begin
                // range word while a start is held closes the mapping
                range_end       = desc << 12;
                r.map_address   = {held_start[19:0], 12'h000};
                r.map_size      = (range_end > r.map_address) ?
                                  range_end - r.map_address : 32'd0;
                r.map_read_only = held_start[20];
                r.map_unk_flag  = desc[20];
                range_held      = 1'b0;
                r.kind          = KIND_RANGE_MAPPED;
            end else begin
                range_held = 1'b0;
                if (desc == DESC_UNUSED) begin
                    r.kind = KIND_UNUSED;
                end else if ((prefix & 12'hF00) == 12'hE00) begin
                    r.kind = KIND_IRQ;
                end else if ((prefix & 12'hF80) == 12'hF00) begin
                    // write up to the highest set bit, never past the mask end
                    group_base = desc[26:24] * 24;
                    for (int k = 0; k < 24; k++) begin
                        pos = group_base + k;
                        if ((desc[23:0] >> k) == 24'd0 || pos >= MASK_BITS) break;
                        access_words[pos / 64][pos % 64] = desc[k];
                    end
                    r.kind = KIND_MASK;
                end else if ((prefix & 12'hFF0) == 12'hFE0) begin
                    handle_size = desc[9:0];
                    r.kind      = KIND_HANDLES;
                end else if ((prefix & 12'hFF8) == 12'hFF0) begin
                    misc_flags = desc[15:0];
                    r.kind     = KIND_FLAGS;
                end else if ((prefix & 12'hFFE) == 12'hFF8) begin
                    // a start marked last is reported but not held
                    if (!last) begin
                        range_held = 1'b1;
                        held_start = desc[20:0];
                    end
                    r.kind = KIND_RANGE_PENDING;
                end else if (prefix == 12'hFFE) begin
                    r.map_address = desc << 12;
                    r.map_size    = PAGE_BYTES;
                    r.kind        = KIND_PAGE;
                end else if ((prefix & 12'hFE0) == 12'hFC0) begin
                    version_hold = desc[15:0];
                    r.kind       = KIND_VERSION;
                end
            end
            r.handle_count   = handle_size;
            r.misc_flag_bits = misc_flags;
            r.version_word   = version_hold;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_field(string name, logic [63:0] exp, logic [63:0] act);
            if (act !== exp) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(t_parse_result act);
            t_parse_result exp;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer: expected none, actual kind %0d",
                         $time, act.kind);
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            check_field("kind",           exp.kind,           act.kind);
            check_field("map_address",    exp.map_address,    act.map_address);
            check_field("map_size",       exp.map_size,       act.map_size);
            check_field("map_read_only",  exp.map_read_only,  act.map_read_only);
            check_field("map_unk_flag",   exp.map_unk_flag,   act.map_unk_flag);
            check_field("handle_count",   exp.handle_count,   act.handle_count);
            check_field("misc_flag_bits", exp.misc_flag_bits, act.misc_flag_bits);
            check_field("version_word",   exp.version_word,   act.version_word);
            check_field("mask_word",      exp.mask_word,      act.mask_word);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    cdp_in_if  in_if ();
    cdp_out_if out_if ();

    capability_descriptor_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_descriptor_scoreboard sb = new();

    bit            no_idle;        // both sides stop idling while set
    bit            long_hold_req;  // receiver picks this up on its next draw
    int            cycles;
    t_parse_result seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any lost or stuck transfer ends up here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_capability_descriptor_parser_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: every transfer goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen.kind           = t_kind'(out_if.kind);
            seen.map_address    = out_if.map_address;
            seen.map_size       = out_if.map_size;
            seen.map_read_only  = out_if.map_read_only;
            seen.map_unk_flag   = out_if.map_unk_flag;
            seen.handle_count   = out_if.handle_count;
            seen.misc_flag_bits = out_if.misc_flag_bits;
            seen.version_word   = out_if.version_word;
            seen.mask_word      = out_if.mask_word;
            sb.check_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random wait per result, plus one long hold on request.
    // The long hold is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        int wait_cycles;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
            if (long_hold_req) begin
                wait_cycles   = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            @(negedge i_clk);
            if (wait_cycles > 0) begin
                out_if.ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // One random bit for single-bit fields
    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one item after a random gap; returns right after the transfer.
    task automatic send_item(bit func, logic [31:0] desc, bit last, bit widx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.func            <= func;
        in_if.descriptor      <= desc;
        in_if.last            <= last;
        in_if.mask_word_index <= widx;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.accept_item(func, desc, last, widx);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain(int settle);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Random descriptor of the given class; the read op is never passed here.
    function automatic logic [31:0] make_descriptor(t_op op);
        logic [31:0] d;
        logic [23:0] bits;
        d    = $urandom;
        bits = 24'($urandom);
        case (op)
            OP_UNUSED:  d = DESC_UNUSED;
            OP_IRQ:     d[31:28] = 4'hE;
            OP_MASK: begin
                // short and sparse groups exercise the early stop
                case ($urandom_range(0, 2))
                    0: bits = bits >> $urandom_range(0, 23);
                    1: bits = bits & 24'($urandom);
                    default: ;
                endcase
                d = {5'b11110, d[26:24], bits};
            end
            OP_HANDLES: d[31:24] = 8'hFE;
            OP_FLAGS:   d[31:23] = 9'h1FE;
            OP_RANGE:   d[31:21] = 11'h7FC;
            OP_PAGE:    d[31:20] = 12'hFFE;
            OP_VERSION: d[31:25] = 7'h7E;
            default: begin
                // the holes in the prefix map
                case ($urandom_range(0, 3))
                    0: d[31:28] = 4'($urandom_range(0, 13));
                    1: d[31:26] = 6'b111110;
                    2: d[31:20] = 12'hFFA + 12'($urandom_range(0, 3));
                    default: d = {12'hFFF, d[19:1], 1'b0};
                endcase
            end
        endcase
        return d;
    endfunction

    // Mostly well-formed range pairs and single descriptors, with broken
    // pairs and reads mixed in.
    task automatic run_random(int n_items);
        int          sent;
        int          sel;
        int          n_reads;
        logic [31:0] start_desc;
        logic [31:0] stop_desc;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                start_desc = make_descriptor(OP_RANGE);
                send_item(FUNC_PARSE, start_desc, 1'b0, rand_bit());
                n_reads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n_reads)
                    send_item(FUNC_READ, $urandom, rand_bit(), rand_bit());
                stop_desc = make_descriptor(OP_RANGE);
                // ends close to the start hit both sides of the size clamp
                if ($urandom_range(0, 1))
                    stop_desc[19:0] = start_desc[19:0] + 20'($urandom_range(0, 8)) - 20'd4;
                send_item(FUNC_PARSE, stop_desc, rand_bit(), rand_bit());
                sent += 2 + n_reads;
            end else if (sel < 40) begin
                // start that is dropped or marked last, then anything
                send_item(FUNC_PARSE, make_descriptor(OP_RANGE), rand_bit(), rand_bit());
                send_item(FUNC_PARSE, make_descriptor(t_op'($urandom_range(0, 8))),
                          rand_bit(), rand_bit());
                sent += 2;
            end else if (sel < 55) begin
                send_item(FUNC_READ, $urandom, rand_bit(), rand_bit());
                sent += 1;
            end else begin
                send_item(FUNC_PARSE, make_descriptor(t_op'($urandom_range(0, 8))),
                          $urandom_range(0, 7) == 0, rand_bit());
                sent += 1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        in_if.valid           = 1'b0;
        in_if.func            = FUNC_PARSE;
        in_if.descriptor      = '0;
        in_if.last            = 1'b0;
        in_if.mask_word_index = 1'b0;
        i_rst_n               = 1'b0;
        no_idle               = 1'b0;
        long_hold_req         = 1'b0;
        cycles                = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, every descriptor class, mask edges, ranges
        send_item(FUNC_READ,  32'h0000_0000, 1'b0, 1'b0);
        send_item(FUNC_READ,  32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(FUNC_PARSE, DESC_UNUSED,   1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hE000_0000, 1'b0, 1'b1);
        send_item(FUNC_PARSE, 32'hF0FF_FFFF, 1'b0, 1'b0);   // group 0, all ones
        send_item(FUNC_PARSE, 32'hF5FF_FFFF, 1'b0, 1'b0);   // straddles the mask end
        send_item(FUNC_PARSE, 32'hF7FF_FFFF, 1'b0, 1'b0);   // entirely past the end
        send_item(FUNC_PARSE, 32'hF100_0005, 1'b0, 1'b0);   // stops after bit 2
        send_item(FUNC_READ,  32'h0000_0000, 1'b0, 1'b0);
        send_item(FUNC_READ,  32'h0000_0000, 1'b0, 1'b1);
        send_item(FUNC_PARSE, 32'hFE00_03FF, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFF00_FFFF, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFC00_FFFF, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFFEF_FFFF, 1'b0, 1'b0);
        // read-only start, read in between, end above start
        send_item(FUNC_PARSE, 32'hFF90_0010, 1'b0, 1'b0);
        send_item(FUNC_READ,  32'h0000_0000, 1'b0, 1'b1);
        send_item(FUNC_PARSE, 32'hFF80_0020, 1'b0, 1'b0);
        // end not above start
        send_item(FUNC_PARSE, 32'hFF8F_FFFF, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFF90_0000, 1'b1, 1'b0);
        // start dropped by a non-range descriptor
        send_item(FUNC_PARSE, 32'hFF80_1000, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFE00_0000, 1'b0, 1'b0);
        // start marked last is not held; the next range word starts afresh
        send_item(FUNC_PARSE, 32'hFF80_0005, 1'b1, 1'b0);
        send_item(FUNC_PARSE, 32'hFF80_0006, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'h0000_0000, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFFFF_FFFE, 1'b0, 1'b0);
        send_item(FUNC_PARSE, 32'hFFA0_0000, 1'b0, 1'b0);
        drain(4);

        // Random with idling on both sides
        run_random(200);

        // Long receiver hold while the sender streams: the queue fills
        no_idle       = 1'b1;
        long_hold_req = 1'b1;
        run_random(20);
        no_idle       = 1'b0;
        drain(4);

        // Back to back, no idling
        no_idle = 1'b1;
        run_random(180);
        no_idle = 1'b0;
        drain(4);

        run_random(200);
        drain(10);

        if (sb.errors == 0) begin
            $display("tb_capability_descriptor_parser_top: clean");
        end else begin
            $display("tb_capability_descriptor_parser_top: errors");
        end
        $finish;
    end

endmodule : tb_capability_descriptor_parser_top

`default_nettype wire

[capability_descriptor_parser_top.f]
rtl/core/cdp_pkg.sv
rtl/core/cdp_if.sv
rtl/core/cdp_front.sv
rtl/core/cdp_queue.sv
rtl/core/cdp_back.sv
rtl/core/capability_descriptor_parser_top.sv
verif/tb_capability_descriptor_parser_top.sv
